/* rtl/wtsp_pkg.sv */
`timescale 1ns / 1ps

package wtsp_pkg;

  // Number of 64-bit matrix registers (two Q16.16 coefficients each)
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 3;

  // Clip w threshold: 0.1 in Q16.16
  localparam logic signed [49:0] W_MIN_RAW = 50'sd6554;

  // Quotient bits produced by the ndc divider (bits 32..0)
  localparam int DIV_N = 33;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } wtsp_in_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } wtsp_out_t;

endpackage

/* rtl/world_to_screen_projection_top.sv */
`timescale 1ns / 1ps

// World-to-screen projection. A world point (Q16.16) is multiplied by the
// 4x4 matrix held in the eight config registers, tested for clip w >= 0.1,
// divided by w and mapped to a saturated 16-bit screen position. The block
// takes one beat per cycle while the output is not stalled; each result
// passes through one multiply stage, one sum stage, one divider setup stage,
// 33 stages of the bit-per-stage restoring divider, the screen multiply
// stage and the output register. The whole pipeline holds while the output
// register is full and stalled. The user must write the config registers
// only while the pipeline is empty; the block does not enforce it.
module world_to_screen_projection_top #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wtsp_pkg::wtsp_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wtsp_pkg::wtsp_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [wtsp_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [wtsp_pkg::REG_W-1:0]        cfg_data
);

  localparam int HW = SCREEN_WIDTH / 2;
  localparam int HH = SCREEN_HEIGHT / 2;
  localparam logic signed [14:0] KX = 15'(HW + 1);
  localparam logic signed [14:0] KY = 15'(1 - HH);
  localparam logic signed [50:0] OFS_X = 51'(HW) <<< 16;
  localparam logic signed [50:0] OFS_Y = 51'(HH) <<< 16;
  localparam int DN = wtsp_pkg::DIV_N;

  // config registers
  logic [wtsp_pkg::REG_W-1:0] cfg_r [wtsp_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wtsp_pkg::NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // coefficient r,c: rows 0,1,3 of the matrix map to r = 0,1,2
  logic signed [31:0] cf [3][4];
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      localparam int ROW = (r == 2) ? 3 : r;
      localparam int IDX = ROW * 2 + c / 2;
      if (c % 2 == 1) begin : g_hi
        assign cf[r][c] = cfg_r[IDX][63:32];
      end else begin : g_lo
        assign cf[r][c] = cfg_r[IDX][31:0];
      end
    end
  end

  // global advance: the pipeline moves unless the output beat is held
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: nine products
  logic signed [31:0] pt [3];
  logic signed [63:0] prod_r [3][3];
  logic               v1_r;
  assign pt[0] = in_data.world_x;
  assign pt[1] = in_data.world_y;
  assign pt[2] = in_data.world_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_r[r][c] <= 64'(cf[r][c]) * 64'(pt[c]);
      end
    end
  end

  // stage 2: floor shift and sum with offset column
  logic signed [49:0] clip_nxt [3];
  logic signed [49:0] clip_r [3];
  logic               v2_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_nxt[r] = 50'(cf[r][3]);
      for (int c = 0; c < 3; c++)
        clip_nxt[r] = clip_nxt[r] + 50'($signed(prod_r[r][c][63:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) clip_r[r] <= clip_nxt[r];
    end
  end

  // stage 3: visibility, magnitudes, overflow test, first remainder
  logic        vis_s3;
  logic        neg_x_s3, neg_y_s3;
  logic [48:0] nx_s3, ny_s3, d_s3;
  logic        ovf_x_s3, ovf_y_s3;

  assign vis_s3   = clip_r[2] >= wtsp_pkg::W_MIN_RAW;
  assign neg_x_s3 = clip_r[0][49];
  assign neg_y_s3 = clip_r[1][49];
  assign nx_s3    = neg_x_s3 ? 49'(-clip_r[0]) : clip_r[0][48:0];
  assign ny_s3    = neg_y_s3 ? 49'(-clip_r[1]) : clip_r[1][48:0];
  assign d_s3     = clip_r[2][48:0];
  assign ovf_x_s3 = {17'd0, nx_s3} >= {d_s3, 17'd0};
  assign ovf_y_s3 = {17'd0, ny_s3} >= {d_s3, 17'd0};

  // divider pipeline registers, index 0 is the setup stage
  logic        dv_v_r    [DN+1];
  logic        dv_vis_r  [DN+1];
  logic [48:0] dv_d_r    [DN+1];
  logic [49:0] dv_rx_r   [DN+1];
  logic [49:0] dv_ry_r   [DN+1];
  logic [16:0] dv_nx_r   [DN+1];
  logic [16:0] dv_ny_r   [DN+1];
  logic [DN-1:0] dv_qx_r [DN+1];
  logic [DN-1:0] dv_qy_r [DN+1];
  logic        dv_sx_r   [DN+1];
  logic        dv_sy_r   [DN+1];
  logic        dv_ox_r   [DN+1];
  logic        dv_oy_r   [DN+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_vis_r[0] <= vis_s3;
      dv_d_r[0]   <= d_s3;
      dv_rx_r[0]  <= 50'(nx_s3[48:17]);
      dv_ry_r[0]  <= 50'(ny_s3[48:17]);
      dv_nx_r[0]  <= nx_s3[16:0];
      dv_ny_r[0]  <= ny_s3[16:0];
      dv_qx_r[0]  <= '0;
      dv_qy_r[0]  <= '0;
      dv_sx_r[0]  <= neg_x_s3;
      dv_sy_r[0]  <= neg_y_s3;
      dv_ox_r[0]  <= ovf_x_s3;
      dv_oy_r[0]  <= ovf_y_s3;
    end
  end

  // one quotient bit per stage; dividend bit i is n[i-16] above bit 15
  for (genvar k = 0; k < DN; k++) begin : g_div
    localparam int BI = DN - 1 - k;
    logic        nbx, nby;
    logic [49:0] tx, ty;
    logic        gx, gy;
    if (BI >= 16) begin : g_nb
      assign nbx = dv_nx_r[k][BI-16];
      assign nby = dv_ny_r[k][BI-16];
    end else begin : g_zero
      assign nbx = 1'b0;
      assign nby = 1'b0;
    end
    assign tx = {dv_rx_r[k][48:0], nbx};
    assign ty = {dv_ry_r[k][48:0], nby};
    assign gx = tx >= {1'b0, dv_d_r[k]};
    assign gy = ty >= {1'b0, dv_d_r[k]};

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_vis_r[k+1] <= dv_vis_r[k];
        dv_d_r[k+1]   <= dv_d_r[k];
        dv_rx_r[k+1]  <= gx ? tx - {1'b0, dv_d_r[k]} : tx;
        dv_ry_r[k+1]  <= gy ? ty - {1'b0, dv_d_r[k]} : ty;
        dv_nx_r[k+1]  <= dv_nx_r[k];
        dv_ny_r[k+1]  <= dv_ny_r[k];
        dv_qx_r[k+1]  <= {dv_qx_r[k][DN-2:0], gx};
        dv_qy_r[k+1]  <= {dv_qy_r[k][DN-2:0], gy};
        dv_sx_r[k+1]  <= dv_sx_r[k];
        dv_sy_r[k+1]  <= dv_sy_r[k];
        dv_ox_r[k+1]  <= dv_ox_r[k];
        dv_oy_r[k+1]  <= dv_oy_r[k];
      end
    end
  end

  // ndc with clamp to 2^33, then screen scale multiply
  logic [33:0]        mag_x, mag_y;
  logic signed [34:0] ndc_x, ndc_y;
  logic signed [49:0] sp_x_r, sp_y_r;
  logic               vm_r, vm_vis_r;

  assign mag_x = dv_ox_r[DN] ? 34'h2_0000_0000 : {1'b0, dv_qx_r[DN]};
  assign mag_y = dv_oy_r[DN] ? 34'h2_0000_0000 : {1'b0, dv_qy_r[DN]};
  assign ndc_x = dv_sx_r[DN] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
  assign ndc_y = dv_sy_r[DN] ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_x_r   <= 50'(KX) * 50'(ndc_x);
      sp_y_r   <= 50'(KY) * 50'(ndc_y);
      vm_vis_r <= dv_vis_r[DN];
    end
  end

  // add half screen, truncate toward zero, saturate
  function automatic logic signed [15:0] sat16(input logic signed [50:0] s);
    logic [50:0] a;
    logic [34:0] i;
    logic signed [15:0] res;
    a = s[50] ? 51'(-s) : s;
    i = a[50:16];
    if (s[50]) res = (i > 35'd32768) ? -16'sd32768 : 16'(-i);
    else       res = (i > 35'd32767) ? 16'sd32767 : 16'(i);
    return res;
  endfunction

  wtsp_pkg::wtsp_out_t out_nxt;
  wtsp_pkg::wtsp_out_t out_r;

  always_comb begin
    out_nxt.visible  = vm_vis_r;
    out_nxt.screen_x = vm_vis_r ? sat16(51'(sp_x_r) + OFS_X) : '0;
    out_nxt.screen_y = vm_vis_r ? sat16(51'(sp_y_r) + OFS_Y) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vm_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DN; k++) dv_v_r[k] <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      dv_v_r[0] <= v2_r;
      for (int k = 0; k < DN; k++) dv_v_r[k+1] <= dv_v_r[k];
      vm_r        <= dv_v_r[DN];
      out_valid_r <= vm_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/wtsp_checker.sv */
`timescale 1ns / 1ps

module wtsp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wtsp_pkg::wtsp_out_t out_data
);

  // a hidden point carries zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |-> out_data.screen_x == 16'sd0 &&
      out_data.screen_y == 16'sd0)
    else $error("hidden point with nonzero screen position");

  // input only stalls behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // held output beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind world_to_screen_projection_top wtsp_checker u_wtsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* test/world_to_screen_projection_checker.sv */
`timescale 1ns / 1ps

module world_to_screen_projection_checker #(
  parameter int SCREEN_WIDTH  = 1920,
  parameter int SCREEN_HEIGHT = 1080
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  wtsp_pkg::wtsp_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  wtsp_pkg::wtsp_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [wtsp_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [wtsp_pkg::REG_W-1:0]      cfg_data,
  output int                              fail_count,
  output int                              pending_count
);

  logic [wtsp_pkg::REG_W-1:0] matrix_regs [wtsp_pkg::NUM_REGS];
  wtsp_pkg::wtsp_out_t        screen_queue [$];

  function automatic longint coef_of(int row, int col);
    logic [63:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  // Each product floors to Q16.16 (arithmetic shift), then exact sum
  function automatic longint clip_of(int row, wtsp_pkg::wtsp_in_t p);
    longint s;
    longint c [3];
    c[0] = longint'(p.world_x);
    c[1] = longint'(p.world_y);
    c[2] = longint'(p.world_z);
    s = coef_of(row, 3);
    for (int k = 0; k < 3; k++) s += (coef_of(row, k) * c[k]) >>> 16;
    return s;
  endfunction

  // num*65536/den toward zero, magnitude clamped at 2^33
  function automatic longint ndc_of(longint num, longint den);
    logic [63:0] n, q, r, mag;
    n = (num < 0) ? -num : num;
    q = n / den;
    r = n % den;
    if (q >= (64'd1 << 17)) mag = 64'd1 << 33;
    else mag = (q << 16) + ((r << 16) / den);
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [15:0] screen_of(longint k, longint ndc, longint half);
    longint s, i;
    s = k * ndc + half * 65536;
    i = (s >= 0) ? (s >>> 16) : -((-s) >>> 16);
    if (i > 32767) i = 32767;
    if (i < -32768) i = -32768;
    return i[15:0];
  endfunction

  function automatic wtsp_pkg::wtsp_out_t project(wtsp_pkg::wtsp_in_t p);
    wtsp_pkg::wtsp_out_t o;
    longint cx, cy, cw, hw, hh;
    hw = SCREEN_WIDTH / 2;
    hh = SCREEN_HEIGHT / 2;
    cx = clip_of(0, p);
    cy = clip_of(1, p);
    cw = clip_of(3, p);
    o = '0;
    if (cw >= 6554) begin
      o.visible  = 1'b1;
      o.screen_x = screen_of(hw + 1, ndc_of(cx, cw), hw);
      o.screen_y = screen_of(1 - hh, ndc_of(cy, cw), hh);
    end
    return o;
  endfunction

  always @(posedge clk) begin
    wtsp_pkg::wtsp_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < wtsp_pkg::NUM_REGS; i++) matrix_regs[i] <= '0;
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) matrix_regs[cfg_index] <= cfg_data;
      if (in_valid && !in_stall) screen_queue.push_back(project(in_data));
      if (out_valid && !out_stall) begin
        if (screen_queue.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = screen_queue.pop_front();
          if (want.visible !== out_data.visible || want.screen_x !== out_data.screen_x ||
              want.screen_y !== out_data.screen_y) begin
            $display("%0t: expected vis=%0d x=%0d y=%0d, got vis=%0d x=%0d y=%0d", $time,
                     want.visible, want.screen_x, want.screen_y,
                     out_data.visible, out_data.screen_x, out_data.screen_y);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= screen_queue.size();
    end
  end

endmodule

/* test/world_to_screen_projection_top_tb.sv */
`timescale 1ns / 1ps

module world_to_screen_projection_top_tb;

  localparam int LATENCY = 38;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wtsp_pkg::wtsp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wtsp_pkg::wtsp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [wtsp_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [wtsp_pkg::REG_W-1:0] cfg_data = '0;
  int fail_count, pending_count;
  int send_idle_pct = 0, recv_idle_pct = 0;
  longint cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  world_to_screen_projection_top DUT (.*);

  world_to_screen_projection_checker checker_i (.*);

  // Receiver stall pattern
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("world_to_screen_projection_top test failed");
      $finish;
    end
  end

  // One beat, with random sender gaps beforehand; valid stays up after
  // acceptance so the next beat can follow directly
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{world_x: x, world_y: y, world_z: z};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx[wtsp_pkg::REG_IDX_W-1:0];
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $signed($urandom_range(40 * 65536)) - 20 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(4))
      0: return $urandom;
      1: return '0;
      default: return $signed($urandom_range(4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  // Random matrix; row 3 mostly yields a positive w near the points
  task automatic load_random_matrix();
    for (int i = 0; i < wtsp_pkg::NUM_REGS; i++) begin
      if (i == 7 && $urandom_range(3) != 0)
        write_reg(i, {ONE * $urandom_range(1, 30), rand_coef()});
      else
        write_reg(i, {rand_coef(), rand_coef()});
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero matrix gives w = 0, never visible
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    drain_pipe();

    // Identity-style matrix, w = 1 + z
    write_reg(0, {32'h0, ONE});
    write_reg(1, {32'h0, 32'h0});
    write_reg(2, {ONE, 32'h0});
    write_reg(3, {32'h0, 32'h0});
    write_reg(4, {32'h0, 32'h0});
    write_reg(5, {32'h0, ONE});
    write_reg(6, {32'h0, 32'h0});
    write_reg(7, {ONE, ONE});
    send_point(0, 0, 0);
    send_point(ONE, ONE, 0);
    send_point(-ONE, -ONE, 0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 0);   // huge ndc, saturates
    send_point(32'h8000_0000, 32'h7fff_ffff, 0);
    send_point(5, 5, 32'hffff_1999);               // w one step below threshold
    send_point(5, 5, 32'hffff_1998);               // w just below
    send_point(ONE, ONE, 32'h8000_0000);           // very negative w
    send_point(ONE, -ONE, 32'h7fff_ffff);          // large w, tiny ndc
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    drain_pipe();

    // Extreme coefficients
    for (int i = 0; i < wtsp_pkg::NUM_REGS; i++) write_reg(i, 64'h8000_0000_7fff_ffff);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    drain_pipe();
    for (int i = 0; i < wtsp_pkg::NUM_REGS; i++) write_reg(i, 64'hffff_ffff_ffff_ffff);
    send_point(32'hffff_ffff, 32'h0, 32'h8000_0000);
    send_point($urandom, $urandom, $urandom);
    drain_pipe();

    // Random phases, new matrix for each
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 8) begin
        send_idle_pct = 58;
        recv_idle_pct = 31;
      end else if (ph < 8) begin
        send_idle_pct = 31;
        recv_idle_pct = 58;
      end else if (ph == 16) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_random_matrix();
      for (int n = 0; n < 48; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        // hold off until the pipe is empty once
        if (ph == 3 && n == 20) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
      end
      drain_pipe();
    end

    if (fail_count == 0) begin
      $display("world_to_screen_projection_top test passed");
    end else begin
      $display("world_to_screen_projection_top test failed");
    end
    $finish;
  end

endmodule
